/* src/iomq_pkg.sv */
// Shared types and constants for the interval overlap max query unit.
// Holds the item structs, table entry type, request and status codes.
// No dependencies.
package iomq_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int TIME_BITS   = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	localparam logic [2:0] STS_OK          = 3'd0;
	localparam logic [2:0] STS_REV_DROPPED = 3'd1;
	localparam logic [2:0] STS_BAD_TAG     = 3'd2;
	localparam logic [2:0] STS_FULL        = 3'd3;
	localparam logic [2:0] STS_REV_WINDOW  = 3'd4;

	localparam logic [1:0] KIND_MAX        = 2'd2;
	localparam logic [2:0] STRENGTH_MAX    = 3'd4;
	localparam logic [2:0] THRESHOLD_RESET = 3'd3;

	localparam logic REG_THRESHOLD = 1'b0;

	typedef struct packed {
		logic [1:0]                  req_type;
		logic signed [TIME_BITS-1:0] start_ms;
		logic signed [TIME_BITS-1:0] end_ms;
		logic [1:0]                  kind_tag;
		logic [2:0]                  strength_tag;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             found;
		logic [2:0]       max_strength;
		logic             significant;
		logic [CNT_W-1:0] entry_total;
	} res_t;

	typedef struct packed {
		logic signed [TIME_BITS-1:0] start_ms;
		logic signed [TIME_BITS-1:0] end_ms;
		logic [2:0]                  strength;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} tbl_rd_t;

endpackage

/* src/iomq_table.sv */
// Interval table storage: one write port, one read port, registered read data.
// Depends on iomq_pkg for the entry and port structs.
module iomq_table (
	input  logic             clk,
	input  iomq_pkg::tbl_wr_t wr,
	input  iomq_pkg::tbl_rd_t rd,
	output iomq_pkg::entry_t  rd_data
);
	import iomq_pkg::*;

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

/* src/interval_overlap_max_query_unit.sv */
// Interval overlap max query unit: clear, insert and query over a 64-entry table.
// Clear, insert, unused and reversed-window query requests skip the scan; the result
// strobes the cycle after accept. A query holds busy while it scans: one table read per
// cycle, then the last registered read data is compared, then the result is latched; done follows busy.
// The receiver cannot stall. Reset clears the count and sets threshold to 3.
// Depends on iomq_pkg and iomq_table.
module interval_overlap_max_query_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  iomq_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output iomq_pkg::res_t res,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import iomq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic             state_q;
	logic             done_q;
	res_t             res_q;
	logic [CNT_W-1:0] count_q;
	logic [2:0]       thr_q;
	logic [CNT_W-1:0] addr_q;
	logic             vld_s1;
	logic             found_q;
	logic [2:0]       max_q;
	logic signed [TIME_BITS-1:0] win_start_q;
	logic signed [TIME_BITS-1:0] win_end_q;

	logic             accept;
	logic             rev;
	logic             bad_tag;
	logic             full;
	logic             go_scan;
	logic             ins_ok;
	logic [CNT_W-1:0] cnt_nxt;
	res_t             imm_res;
	res_t             scan_res;
	logic             rd_en;
	logic             scan_end;
	logic             hit;
	logic             cfg_wr;
	tbl_wr_t          tbl_wr;
	tbl_rd_t          tbl_rd;
	entry_t           rd_data;

	assign accept  = start && (state_q == S_IDLE);
	assign rev     = req.end_ms < req.start_ms;
	assign bad_tag = (req.kind_tag > KIND_MAX) || (req.strength_tag > STRENGTH_MAX);
	assign full    = count_q >= CNT_W'(TABLE_DEPTH);
	assign go_scan = accept && (req.req_type == REQ_QUERY) && !rev;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		imm_res = '0;
		imm_res.entry_total = count_q;
		ins_ok  = 1'b0;
		cnt_nxt = count_q;
		case (req.req_type)
			REQ_CLEAR: begin
				cnt_nxt = '0;
				imm_res.entry_total = '0;
			end
			REQ_INSERT: begin
				if (rev) begin
					imm_res.status = STS_REV_DROPPED;
				end else if (bad_tag) begin
					imm_res.status = STS_BAD_TAG;
				end else if (full) begin
					imm_res.status = STS_FULL;
				end else begin
					ins_ok  = 1'b1;
					cnt_nxt = count_q + 1'b1;
					imm_res.entry_total = cnt_nxt;
				end
			end
			REQ_QUERY: begin
				if (rev) begin
					imm_res.status = STS_REV_WINDOW;
				end
			end
			default: begin
			end
		endcase
	end

	// Writes happen only when idle and reads only during a scan, so the ports never collide.
	assign tbl_wr.en   = accept && (req.req_type == REQ_INSERT) && ins_ok;
	assign tbl_wr.addr = count_q[IDX_W-1:0];
	assign tbl_wr.data = '{start_ms: req.start_ms, end_ms: req.end_ms,
		strength: req.strength_tag};

	assign rd_en       = (state_q == S_SCAN) && (addr_q < count_q);
	assign tbl_rd.en   = rd_en;
	assign tbl_rd.addr = addr_q[IDX_W-1:0];
	assign scan_end    = (state_q == S_SCAN) && !rd_en && !vld_s1;

	iomq_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (rd_data)
	);

	assign hit = vld_s1 && (rd_data.start_ms <= win_end_q) && (rd_data.end_ms >= win_start_q);

	always_comb begin
		scan_res              = '0;
		scan_res.status       = STS_OK;
		scan_res.found        = found_q;
		scan_res.max_strength = max_q;
		scan_res.significant  = found_q && (max_q >= thr_q);
		scan_res.entry_total  = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
			thr_q   <= THRESHOLD_RESET;
			vld_s1  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= rd_en;
			if (cfg_wr && (paddr[2] == REG_THRESHOLD)) begin
				thr_q <= pwdata[2:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (go_scan) begin
							state_q <= S_SCAN;
						end else begin
							done_q  <= 1'b1;
							count_q <= cnt_nxt;
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q       <= imm_res;
			win_start_q <= req.start_ms;
			win_end_q   <= req.end_ms;
			addr_q      <= '0;
			found_q     <= 1'b0;
			max_q       <= '0;
		end else if (state_q == S_SCAN) begin
			if (rd_en) begin
				addr_q <= addr_q + 1'b1;
			end
			if (hit) begin
				found_q <= 1'b1;
				if (rd_data.strength > max_q) begin
					max_q <= rd_data.strength;
				end
			end
			if (scan_end) begin
				res_q <= scan_res;
			end
		end
	end

	assign busy   = (state_q == S_SCAN);
	assign done   = done_q;
	assign res    = res_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESHOLD) ? {29'd0, thr_q} : 32'd0;

endmodule
